FILE: rtl/ppm_pkg.sv
// Package for the polygon point membership unit: widths, actions, sequencer states.
// No dependencies.
`default_nettype none
package ppm_pkg;
  localparam int MaxVertices = 64;
  localparam int CoordBits   = 12;
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int CntBits     = $clog2(MaxVertices + 1);
  localparam int VtxBits     = 2 * CoordBits;
  localparam int DiffBits    = CoordBits + 2;          // coordinate differences
  localparam int ProdBits    = 2 * DiffBits + 2;       // products and their sums
  localparam int WideBits    = 2 * ProdBits;           // squared cross product
  localparam int CfgAddrBits = 4;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [CfgAddrBits-1:0] REG_BORDER  = 4'h0;
  localparam logic [CfgAddrBits-1:0] REG_OUTLINE = 4'h4;
  localparam logic [CfgAddrBits-1:0] REG_OPEN    = 4'h8;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_RD2, ST_LOAD, ST_M_CR1, ST_M_CR2, ST_M_L1, ST_M_L2,
    ST_M_DOT1, ST_M_DOT2, ST_M_D1, ST_M_D2, ST_M_W, ST_M_SQA, ST_M_SQB,
    ST_EDGE, ST_M_XP, ST_DIV, ST_CROSS, ST_NEXT, ST_OUT
  } state_t;
endpackage
`default_nettype wire

FILE: rtl/ppm_if.sv
// Valid/ready channel interfaces for the polygon point membership unit.
// Depends on ppm_pkg.
`default_nettype none
interface ppm_in_if (input wire logic clk);
  import ppm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic signed [CoordBits-1:0] coord_x;
  logic signed [CoordBits-1:0] coord_y;
  modport source (output valid, action, coord_x, coord_y, input ready);
  modport sink (input valid, action, coord_x, coord_y, output ready);
endinterface

interface ppm_out_if (input wire logic clk);
  logic valid;
  logic ready;
  logic hit;
  logic status;
  modport source (output valid, hit, status, input ready);
  modport sink (input valid, hit, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/polygon_point_membership_unit.sv
// Polygon point membership unit. A clear or append word moves the sequencer from
// ST_IDLE to ST_OUT, which sets the registered result valid. A query walks every
// stored edge through one shared multiplier and a one-bit-per-cycle restoring
// divider. Each edge reads both vertices, then forms the cross product, squared edge
// length, dot product, squared vertex distance and squared border width and compares;
// unless outline mode is set, an edge that straddles the point's row adds one
// multiply, the divide and one compare. A query on an empty table goes straight to
// the answer. It ends early on the first border or vertex hit. The vertex table is
// one RAM port, read twice per edge. One item is in work at a time; the result
// register frees the input side once taken.
// Depends on ppm_pkg, ppm_if and ppm_ram.
`default_nettype none
module polygon_point_membership_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  ppm_in_if.sink                            in_ch,
  ppm_out_if.source                         out_ch,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [ppm_pkg::CfgAddrBits-1:0] cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output      logic [31:0]                  cfg_prdata,
  output      logic                         cfg_pready
);
  import ppm_pkg::*;

  localparam int QBits = ProdBits;  // divider quotient width

  // configuration registers
  logic [7:0] border_r;
  logic       outline_r, open_r;
  logic       cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      border_r  <= 8'd1;
      outline_r <= 1'b0;
      open_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_paddr)
        REG_BORDER:  border_r  <= cfg_pwdata[7:0];
        REG_OUTLINE: outline_r <= cfg_pwdata[0];
        REG_OPEN:    open_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_BORDER:  cfg_prdata = {24'd0, border_r};
      REG_OUTLINE: cfg_prdata = {31'd0, outline_r};
      REG_OPEN:    cfg_prdata = {31'd0, open_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  // vertex table
  logic               ram_we;
  logic [IdxBits-1:0] ram_addr;
  logic [VtxBits-1:0] ram_wdata, ram_rdata;

  ppm_ram #(.Width(VtxBits), .Depth(MaxVertices)) u_vtx (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // sequencer and datapath registers
  state_t state_r, state_nxt;
  logic [CntBits-1:0] count_r, count_nxt;
  logic [CntBits-1:0] i_r, i_nxt;
  logic signed [CoordBits-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [CoordBits-1:0] x1_r, x1_nxt, y1_r, y1_nxt;
  logic signed [DiffBits-1:0] pdx_r, pdx_nxt, pdy_r, pdy_nxt, dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [ProdBits-1:0] acc_r, acc_nxt, cr_r, cr_nxt, lsq_r, lsq_nxt;
  logic signed [ProdBits-1:0] dot_r, dot_nxt, dd_r, dd_nxt, wsq_r, wsq_nxt;
  logic [WideBits-1:0] sqa_r, sqa_nxt;
  logic       cnt_r, cnt_nxt, hit_r, hit_nxt, status_r, status_nxt, ovalid_r, ovalid_nxt;
  // divider
  logic [QBits-1:0] num_r, num_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic [QBits:0]   rem_r, rem_nxt;
  logic [$clog2(QBits+1)-1:0] dcnt_r, dcnt_nxt;
  logic       qneg_r, qneg_nxt;

  // shared multiplier operands
  logic signed [ProdBits-1:0] ma, mb;
  logic signed [WideBits-1:0] mprod;
  assign mprod = WideBits'(ma) * WideBits'(mb);

  logic [CntBits-1:0] j_idx;
  logic signed [CoordBits-1:0] rx, ry;
  logic [QBits:0] rem_sh;
  logic [7:0] w_eff;
  logic signed [ProdBits-1:0] quo_s;
  logic use_border;

  assign rx = ram_rdata[VtxBits-1:CoordBits];
  assign ry = ram_rdata[CoordBits-1:0];
  assign j_idx = (i_r + 1'b1 == count_r) ? '0 : CntBits'(i_r + 1'b1);
  assign w_eff = (border_r == 8'd0) ? 8'd1 : border_r;
  assign rem_sh = {rem_r[QBits-1:0], num_r[QBits-1]};
  assign quo_s = qneg_r ? -$signed(quo_r) : $signed(quo_r);
  assign use_border = (i_r + 1'b1 != count_r) || !open_r;
  assign in_ch.ready = (state_r == ST_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.hit = hit_r;
  assign out_ch.status = status_r;

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
    end
    i_r <= i_nxt; px_r <= px_nxt; py_r <= py_nxt; x1_r <= x1_nxt; y1_r <= y1_nxt;
    pdx_r <= pdx_nxt; pdy_r <= pdy_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt;
    acc_r <= acc_nxt; cr_r <= cr_nxt; lsq_r <= lsq_nxt; dot_r <= dot_nxt;
    dd_r <= dd_nxt; wsq_r <= wsq_nxt; sqa_r <= sqa_nxt; cnt_r <= cnt_nxt;
    hit_r <= hit_nxt; status_r <= status_nxt;
    num_r <= num_nxt; quo_r <= quo_nxt; den_r <= den_nxt; rem_r <= rem_nxt;
    dcnt_r <= dcnt_nxt; qneg_r <= qneg_nxt;
  end

  // sequencer: next state, datapath updates, multiplier selection
  always_comb begin
    state_nxt = state_r; count_nxt = count_r; ovalid_nxt = ovalid_r;
    i_nxt = i_r; px_nxt = px_r; py_nxt = py_r; x1_nxt = x1_r; y1_nxt = y1_r;
    pdx_nxt = pdx_r; pdy_nxt = pdy_r; dx_nxt = dx_r; dy_nxt = dy_r;
    acc_nxt = acc_r; cr_nxt = cr_r; lsq_nxt = lsq_r; dot_nxt = dot_r;
    dd_nxt = dd_r; wsq_nxt = wsq_r; sqa_nxt = sqa_r; cnt_nxt = cnt_r;
    hit_nxt = hit_r; status_nxt = status_r;
    num_nxt = num_r; quo_nxt = quo_r; den_nxt = den_r; rem_nxt = rem_r;
    dcnt_nxt = dcnt_r; qneg_nxt = qneg_r;
    ram_we = 1'b0;
    ram_addr = i_r[IdxBits-1:0];
    ram_wdata = {px_r, py_r};
    ma = '0; mb = '0;

    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          px_nxt = in_ch.coord_x; py_nxt = in_ch.coord_y;
          hit_nxt = 1'b0; status_nxt = 1'b0; cnt_nxt = 1'b0; i_nxt = '0;
          case (action_t'(in_ch.action))
            ACT_CLEAR: begin
              count_nxt = '0; state_nxt = ST_OUT;
            end
            ACT_APPEND: begin
              if (count_r < CntBits'(MaxVertices)) begin
                ram_we = 1'b1;
                ram_addr = count_r[IdxBits-1:0];
                ram_wdata = {in_ch.coord_x, in_ch.coord_y};
                count_nxt = CntBits'(count_r + 1'b1);
              end else begin
                status_nxt = 1'b1;
              end
              state_nxt = ST_OUT;
            end
            ACT_QUERY: state_nxt = (count_r == '0) ? ST_OUT : ST_RD;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      // read vertex i, then vertex j
      ST_RD: begin
        ram_addr = i_r[IdxBits-1:0];
        state_nxt = ST_RD2;
      end
      ST_RD2: begin
        ram_addr = j_idx[IdxBits-1:0];
        x1_nxt = rx; y1_nxt = ry;
        dx_nxt = DiffBits'(px_r) - DiffBits'(rx);
        dy_nxt = DiffBits'(py_r) - DiffBits'(ry);
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        pdx_nxt = DiffBits'(rx) - DiffBits'(x1_r);
        pdy_nxt = DiffBits'(ry) - DiffBits'(y1_r);
        state_nxt = ST_M_CR1;
      end
      // cross product dx*pdy - dy*pdx
      ST_M_CR1: begin
        ma = ProdBits'(dx_r); mb = ProdBits'(pdy_r);
        acc_nxt = ProdBits'(mprod); state_nxt = ST_M_CR2;
      end
      ST_M_CR2: begin
        ma = ProdBits'(dy_r); mb = ProdBits'(pdx_r);
        cr_nxt = acc_r - ProdBits'(mprod); state_nxt = ST_M_L1;
      end
      // squared edge length
      ST_M_L1: begin
        ma = ProdBits'(pdx_r); mb = ProdBits'(pdx_r);
        acc_nxt = ProdBits'(mprod); state_nxt = ST_M_L2;
      end
      ST_M_L2: begin
        ma = ProdBits'(pdy_r); mb = ProdBits'(pdy_r);
        lsq_nxt = acc_r + ProdBits'(mprod); state_nxt = ST_M_DOT1;
      end
      // projection dot product
      ST_M_DOT1: begin
        ma = ProdBits'(dx_r); mb = ProdBits'(pdx_r);
        acc_nxt = ProdBits'(mprod); state_nxt = ST_M_DOT2;
      end
      ST_M_DOT2: begin
        ma = ProdBits'(dy_r); mb = ProdBits'(pdy_r);
        dot_nxt = acc_r + ProdBits'(mprod); state_nxt = ST_M_D1;
      end
      // squared vertex distance
      ST_M_D1: begin
        ma = ProdBits'(dx_r); mb = ProdBits'(dx_r);
        acc_nxt = ProdBits'(mprod); state_nxt = ST_M_D2;
      end
      ST_M_D2: begin
        ma = ProdBits'(dy_r); mb = ProdBits'(dy_r);
        dd_nxt = acc_r + ProdBits'(mprod); state_nxt = ST_M_W;
      end
      ST_M_W: begin
        ma = ProdBits'(w_eff); mb = ProdBits'(w_eff);
        wsq_nxt = ProdBits'(mprod); state_nxt = ST_M_SQA;
      end
      // d*d against w*w*lsq
      ST_M_SQA: begin
        ma = cr_r; mb = cr_r;
        sqa_nxt = WideBits'(mprod); state_nxt = ST_M_SQB;
      end
      ST_M_SQB: begin
        ma = wsq_r; mb = lsq_r;
        if (use_border && (sqa_r < WideBits'(mprod)) && !dot_r[ProdBits-1]
            && (dot_r <= lsq_r)) begin
          hit_nxt = 1'b1; state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_EDGE;
        end
      end
      ST_EDGE: begin
        if (dd_r < wsq_r) begin
          hit_nxt = 1'b1; state_nxt = ST_OUT;
        end else if (!outline_r && ((y1_r <= py_r) != ((y1_r + pdy_r) <= py_r))) begin
          state_nxt = ST_M_XP;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      // dy*pdx, then truncating divide by pdy
      ST_M_XP: begin
        ma = ProdBits'(dy_r); mb = ProdBits'(pdx_r);
        acc_nxt = ProdBits'(mprod);
        num_nxt = mprod[ProdBits-1] ? QBits'(-mprod) : QBits'(mprod);
        den_nxt = pdy_r[DiffBits-1] ? QBits'(-pdy_r) : QBits'(pdy_r);
        qneg_nxt = mprod[ProdBits-1] ^ pdy_r[DiffBits-1];
        rem_nxt = '0; quo_nxt = '0; dcnt_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        num_nxt = {num_r[QBits-2:0], 1'b0};
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r};
          quo_nxt = {quo_r[QBits-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[QBits-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == ($bits(dcnt_r))'(QBits - 1)) state_nxt = ST_CROSS;
      end
      ST_CROSS: begin
        if (ProdBits'(dx_r) > quo_s) cnt_nxt = ~cnt_r;
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (i_r + 1'b1 == count_r) begin
          hit_nxt = cnt_r; state_nxt = ST_OUT;
        end else begin
          i_nxt = CntBits'(i_r + 1'b1); state_nxt = ST_RD;
        end
      end
      ST_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1; state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/ppm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ppm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
